// ----- rtl/rdrw_pkg.sv -----
package rdrw_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 16;
    localparam int unsigned AddrWidth     = 8;
    localparam int unsigned CodeWidth     = 8;
    localparam int unsigned QuietWidth    = 16;

    localparam logic [QuietWidth-1:0] QuietMax = '1;

    typedef enum logic [2:0] {
        HEAD_NONE  = 3'd0,
        HEAD_FWD   = 3'd1,
        HEAD_BACK  = 3'd2,
        HEAD_LEFT  = 3'd3,
        HEAD_RIGHT = 3'd4
    } heading_t;

    typedef enum logic [1:0] {
        DRV_COAST = 2'd0,
        DRV_FWD   = 2'd1,
        DRV_REV   = 2'd2
    } drive_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_STATION_ADDR     = 3'd0,
        REG_CODE_FORWARD     = 3'd1,
        REG_CODE_BACKWARD    = 3'd2,
        REG_CODE_PIVOT_LEFT  = 3'd3,
        REG_CODE_PIVOT_RIGHT = 3'd4,
        REG_CODE_HALT        = 3'd5,
        REG_RELEASE_TIMEOUT  = 3'd6,
        REG_UNUSED           = 3'd7
    } cfg_index_t;

    localparam logic [AddrWidth-1:0]  StationAddrReset    = 8'h00;
    localparam logic [CodeWidth-1:0]  CodeForwardReset    = 8'h18;
    localparam logic [CodeWidth-1:0]  CodeBackwardReset   = 8'h52;
    localparam logic [CodeWidth-1:0]  CodePivotLeftReset  = 8'h08;
    localparam logic [CodeWidth-1:0]  CodePivotRightReset = 8'h5A;
    localparam logic [CodeWidth-1:0]  CodeHaltReset       = 8'h1C;
    localparam logic [QuietWidth-1:0] ReleaseTimeoutReset = 16'd200;

    typedef struct packed {
        logic [AddrWidth-1:0]  station_addr;
        logic [CodeWidth-1:0]  code_forward;
        logic [CodeWidth-1:0]  code_backward;
        logic [CodeWidth-1:0]  code_pivot_left;
        logic [CodeWidth-1:0]  code_pivot_right;
        logic [CodeWidth-1:0]  code_halt;
        logic [QuietWidth-1:0] release_timeout;
    } cfg_t;

    // first match wins: forward, backward, pivot left, pivot right
    function automatic heading_t map_code(input cfg_t cfg, input logic [CodeWidth-1:0] cmd);
        heading_t h;
        if (cmd == cfg.code_forward)
        begin
            h = HEAD_FWD;
        end
        else if (cmd == cfg.code_backward)
        begin
            h = HEAD_BACK;
        end
        else if (cmd == cfg.code_pivot_left)
        begin
            h = HEAD_LEFT;
        end
        else if (cmd == cfg.code_pivot_right)
        begin
            h = HEAD_RIGHT;
        end
        else
        begin
            h = HEAD_NONE;
        end
        return h;
    endfunction

endpackage

// ----- rtl/remote_drive_release_watchdog.sv -----
// Drive controller for a remote-controlled two-motor platform.
// Input channel (in_valid / in_stall): one request is either a decoded remote
// frame (action = 0) or a one-millisecond tick (action = 1).
// Output channel (out_valid / out_stall): exactly one result per request with
// both motor drives, the heading, and auto-stop / halt flags.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
// index 0..6 selects address, five command codes and the release timeout.
// Byte registers take cfg_data[7:0]; index 7 is ignored.
// Path: accepted requests go into the input register, then decode / counter
// update into the result register; out_valid rises when that register loads.
// Throughput: one request per cycle while out_stall is low; the heading and
// quiet counter update in the same cycle the result register loads.
// When out_stall is high, the result holds and the input register can still
// take one request; in_stall rises only when both registers are full.
// Reset: heading none, quiet count 0, config at default codes, both
// registers empty.
module remote_drive_release_watchdog (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic                                frame_ok,
    input  logic [rdrw_pkg::AddrWidth-1:0]      frame_address,
    input  logic [rdrw_pkg::CodeWidth-1:0]      frame_command,
    input  logic                                is_repeat,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          left_drive,
    output logic [1:0]                          right_drive,
    output logic [2:0]                          heading,
    output logic                                auto_stopped,
    output logic                                halt_pressed,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rdrw_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [rdrw_pkg::CfgDataWidth-1:0]   cfg_data
);
    import rdrw_pkg::*;

    cfg_t cfg;

    logic                   ival_reg;
    logic                   ival_next;
    logic                   act_reg;
    logic                   ok_reg;
    logic [AddrWidth-1:0]   addr_reg;
    logic [CodeWidth-1:0]   cmd_reg;
    logic                   rep_reg;

    heading_t               heading_reg;
    heading_t               heading_next;
    logic [QuietWidth-1:0]  quiet_reg;
    logic [QuietWidth-1:0]  quiet_next;

    logic                   oval_reg;
    logic                   oval_next;
    drive_t                 left_reg;
    drive_t                 left_next;
    drive_t                 right_reg;
    drive_t                 right_next;
    logic                   auto_reg;
    logic                   auto_next;
    logic                   halt_reg;
    logic                   halt_next;

    logic                   adv;
    logic                   in_accept;
    logic                   frame_hit;
    heading_t               mapped;
    heading_t               head_mid;

    rdrw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign adv       = !oval_reg || !out_stall;
    assign in_stall  = ival_reg && !adv;
    assign in_accept = in_valid && !in_stall;
    assign ival_next = in_accept ? 1'b1 : (adv ? 1'b0 : ival_reg);
    assign oval_next = adv ? ival_reg : oval_reg;

    always_comb
    begin
        frame_hit  = !act_reg && ok_reg && (addr_reg == cfg.station_addr);
        mapped     = map_code(cfg, cmd_reg);
        head_mid   = heading_reg;
        quiet_next = quiet_reg;
        halt_next  = 1'b0;
        auto_next  = 1'b0;

        if (act_reg)
        begin
            if (quiet_reg != QuietMax)
                quiet_next = quiet_reg + 1'b1;
        end
        else if (frame_hit)
        begin
            if (!rep_reg && cmd_reg == cfg.code_halt)
            begin
                head_mid  = HEAD_NONE;
                halt_next = 1'b1;
            end
            else if (!rep_reg)
            begin
                if (mapped != HEAD_NONE)
                begin
                    head_mid   = mapped;
                    quiet_next = '0;
                end
            end
            else if (heading_reg != HEAD_NONE && mapped == heading_reg)
            begin
                quiet_next = '0;
            end
        end

        heading_next = head_mid;
        if (head_mid != HEAD_NONE && quiet_next > cfg.release_timeout)
        begin
            heading_next = HEAD_NONE;
            auto_next    = 1'b1;
        end

        unique case (heading_next)
            HEAD_FWD:   begin left_next = DRV_FWD; right_next = DRV_FWD; end
            HEAD_BACK:  begin left_next = DRV_REV; right_next = DRV_REV; end
            HEAD_LEFT:  begin left_next = DRV_REV; right_next = DRV_FWD; end
            HEAD_RIGHT: begin left_next = DRV_FWD; right_next = DRV_REV; end
            default:    begin left_next = DRV_COAST; right_next = DRV_COAST; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ival_reg    <= 1'b0;
            oval_reg    <= 1'b0;
            heading_reg <= HEAD_NONE;
            quiet_reg   <= '0;
        end
        else
        begin
            ival_reg <= ival_next;
            oval_reg <= oval_next;
            if (adv && ival_reg)
            begin
                heading_reg <= heading_next;
                quiet_reg   <= quiet_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg  <= action;
            ok_reg   <= frame_ok;
            addr_reg <= frame_address;
            cmd_reg  <= frame_command;
            rep_reg  <= is_repeat;
        end
        if (adv && ival_reg)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            auto_reg  <= auto_next;
            halt_reg  <= halt_next;
        end
    end

    assign out_valid    = oval_reg;
    assign left_drive   = left_reg;
    assign right_drive  = right_reg;
    assign heading      = heading_reg;
    assign auto_stopped = auto_reg;
    assign halt_pressed = halt_reg;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(auto_stopped && halt_pressed))
        else $error("auto stop and halt in the same result");

    a_stop_coasts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (auto_stopped || halt_pressed) |->
            heading == HEAD_NONE && left_drive == DRV_COAST && right_drive == DRV_COAST)
        else $error("stop result does not coast");

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ival_reg && out_valid)
        else $error("input stalled with a free register");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !(adv && ival_reg) |=> $stable(heading_reg) && $stable(quiet_reg))
        else $error("state changed without a request");
`endif

endmodule

// ----- rtl/rdrw_cfg.sv -----
module rdrw_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rdrw_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [rdrw_pkg::CfgDataWidth-1:0]   cfg_data,
    output rdrw_pkg::cfg_t                      cfg
);
    import rdrw_pkg::*;

    cfg_t       cfg_reg;
    cfg_index_t idx;

    assign cfg_ready = 1'b1;
    assign idx       = cfg_index_t'(cfg_index);
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.station_addr     <= StationAddrReset;
            cfg_reg.code_forward     <= CodeForwardReset;
            cfg_reg.code_backward    <= CodeBackwardReset;
            cfg_reg.code_pivot_left  <= CodePivotLeftReset;
            cfg_reg.code_pivot_right <= CodePivotRightReset;
            cfg_reg.code_halt        <= CodeHaltReset;
            cfg_reg.release_timeout  <= ReleaseTimeoutReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (idx)
                REG_STATION_ADDR:     cfg_reg.station_addr     <= cfg_data[AddrWidth-1:0];
                REG_CODE_FORWARD:     cfg_reg.code_forward     <= cfg_data[CodeWidth-1:0];
                REG_CODE_BACKWARD:    cfg_reg.code_backward    <= cfg_data[CodeWidth-1:0];
                REG_CODE_PIVOT_LEFT:  cfg_reg.code_pivot_left  <= cfg_data[CodeWidth-1:0];
                REG_CODE_PIVOT_RIGHT: cfg_reg.code_pivot_right <= cfg_data[CodeWidth-1:0];
                REG_CODE_HALT:        cfg_reg.code_halt        <= cfg_data[CodeWidth-1:0];
                REG_RELEASE_TIMEOUT:  cfg_reg.release_timeout  <= cfg_data[QuietWidth-1:0];
                default:              ;
            endcase
        end
    end

endmodule

// ----- test/tb_remote_drive_release_watchdog.sv -----
module tb_remote_drive_release_watchdog;
    timeunit 1ns;
    timeprecision 1ps;

    import rdrw_pkg::*;

    localparam int unsigned StallLimit   = 2000;
    localparam int unsigned DrainCycles  = 4;
    localparam int unsigned RandomItems  = 1250;
    localparam int unsigned RandomPhases = 5;

    localparam logic [CodeWidth-1:0] CodeLow     = 8'h00;
    localparam logic [CodeWidth-1:0] CodeHigh    = 8'hFF;
    localparam logic [AddrWidth-1:0] AddrHigh    = 8'hFF;
    localparam logic [QuietWidth-1:0] TimeoutMin = 16'd1;
    localparam logic [QuietWidth-1:0] TimeoutMax = 16'd65534;

    localparam cfg_t CfgDefault = '{
        station_addr:     StationAddrReset,
        code_forward:     CodeForwardReset,
        code_backward:    CodeBackwardReset,
        code_pivot_left:  CodePivotLeftReset,
        code_pivot_right: CodePivotRightReset,
        code_halt:        CodeHaltReset,
        release_timeout:  ReleaseTimeoutReset
    };

    typedef struct packed {
        logic                 tick;
        logic                 ok;
        logic [AddrWidth-1:0] addr;
        logic [CodeWidth-1:0] cmd;
        logic                 rep;
    } remote_req_t;

    typedef struct packed {
        logic [1:0] left;
        logic [1:0] right;
        logic [2:0] head;
        logic       auto_stop;
        logic       halt;
    } drive_res_t;

    typedef struct packed {
        logic                    is_cfg;
        cfg_index_t              idx;
        logic [CfgDataWidth-1:0] data;
        remote_req_t             req;
        logic                    has_exp;
        drive_res_t              exp;
    } step_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     action;
    logic                     frame_ok;
    logic [AddrWidth-1:0]     frame_address;
    logic [CodeWidth-1:0]     frame_command;
    logic                     is_repeat;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               left_drive;
    logic [1:0]               right_drive;
    logic [2:0]               heading;
    logic                     auto_stopped;
    logic                     halt_pressed;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;

    cfg_t                  mirror_cfg;
    heading_t              mirror_heading;
    logic [QuietWidth-1:0] mirror_quiet;
    drive_res_t            drive_expected[$];
    step_row_t             dir_table[$];

    int unsigned mismatch_count;
    int unsigned stuck_cycles;
    int unsigned rx_mode;
    int unsigned rx_cycle;
    bit          gaps_on;
    int unsigned burst_left;

    remote_drive_release_watchdog DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .frame_ok      (frame_ok),
        .frame_address (frame_address),
        .frame_command (frame_command),
        .is_repeat     (is_repeat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_drive    (left_drive),
        .right_drive   (right_drive),
        .heading       (heading),
        .auto_stopped  (auto_stopped),
        .halt_pressed  (halt_pressed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic heading_t code_heading(logic [CodeWidth-1:0] cmd);
        heading_t h;
        h = HEAD_NONE;
        if (cmd == mirror_cfg.code_pivot_right) h = HEAD_RIGHT;
        if (cmd == mirror_cfg.code_pivot_left)  h = HEAD_LEFT;
        if (cmd == mirror_cfg.code_backward)    h = HEAD_BACK;
        if (cmd == mirror_cfg.code_forward)     h = HEAD_FWD;
        return h;
    endfunction

    function automatic drive_res_t predict_drive(remote_req_t r);
        drive_res_t res;
        heading_t   nxt;
        res = '0;
        if (r.tick)
        begin
            if (mirror_quiet != QuietMax)
                mirror_quiet = mirror_quiet + 1'b1;
        end
        else if (r.ok && r.addr == mirror_cfg.station_addr)
        begin
            if (!r.rep && r.cmd == mirror_cfg.code_halt)
            begin
                mirror_heading = HEAD_NONE;
                res.halt = 1'b1;
            end
            else if (!r.rep)
            begin
                nxt = code_heading(r.cmd);
                if (nxt != HEAD_NONE)
                begin
                    mirror_heading = nxt;
                    mirror_quiet = '0;
                end
            end
            else if (mirror_heading != HEAD_NONE && code_heading(r.cmd) == mirror_heading)
            begin
                mirror_quiet = '0;
            end
        end
        if (mirror_heading != HEAD_NONE && mirror_quiet > mirror_cfg.release_timeout)
        begin
            mirror_heading = HEAD_NONE;
            res.auto_stop = 1'b1;
        end
        case (mirror_heading)
            HEAD_FWD:   begin res.left = DRV_FWD; res.right = DRV_FWD; end
            HEAD_BACK:  begin res.left = DRV_REV; res.right = DRV_REV; end
            HEAD_LEFT:  begin res.left = DRV_REV; res.right = DRV_FWD; end
            HEAD_RIGHT: begin res.left = DRV_FWD; res.right = DRV_REV; end
            default:    begin res.left = DRV_COAST; res.right = DRV_COAST; end
        endcase
        res.head = mirror_heading;
        return res;
    endfunction

    function automatic step_row_t req_row(logic tick, logic ok, logic [AddrWidth-1:0] addr,
                                          logic [CodeWidth-1:0] cmd, logic rep);
        step_row_t r;
        r = '0;
        r.req.tick = tick;
        r.req.ok   = ok;
        r.req.addr = addr;
        r.req.cmd  = cmd;
        r.req.rep  = rep;
        return r;
    endfunction

    function automatic step_row_t with_exp(step_row_t r, drive_t l, drive_t rt, heading_t h,
                                           logic a, logic hp);
        step_row_t o;
        o = r;
        o.has_exp       = 1'b1;
        o.exp.left      = l;
        o.exp.right     = rt;
        o.exp.head      = h;
        o.exp.auto_stop = a;
        o.exp.halt      = hp;
        return o;
    endfunction

    function automatic step_row_t cfg_row(cfg_index_t idx, logic [CfgDataWidth-1:0] data);
        step_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic remote_req_t random_req();
        remote_req_t r;
        r.tick = ($urandom_range(0, 99) < 35);
        r.ok   = ($urandom_range(0, 9) != 0);
        r.addr = ($urandom_range(0, 9) != 0) ? mirror_cfg.station_addr : AddrWidth'($urandom);
        case ($urandom_range(0, 5))
            0:       r.cmd = mirror_cfg.code_forward;
            1:       r.cmd = mirror_cfg.code_backward;
            2:       r.cmd = mirror_cfg.code_pivot_left;
            3:       r.cmd = mirror_cfg.code_pivot_right;
            4:       r.cmd = mirror_cfg.code_halt;
            default: r.cmd = CodeWidth'($urandom);
        endcase
        r.rep = ($urandom_range(0, 2) == 0);
        return r;
    endfunction

    task automatic send_req(remote_req_t r, logic typed, drive_res_t typed_res);
        drive_res_t predicted;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                end
                burst_left = $urandom_range(1, 30);
            end
            burst_left--;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        action        <= r.tick;
        frame_ok      <= r.ok;
        frame_address <= r.addr;
        frame_command <= r.cmd;
        is_repeat     <= r.rep;
        do @(posedge clk); while (in_stall);
        predicted = predict_drive(r);
        drive_expected.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (drive_expected.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_index_t idx, logic [CfgDataWidth-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_STATION_ADDR:     mirror_cfg.station_addr     = data[AddrWidth-1:0];
            REG_CODE_FORWARD:     mirror_cfg.code_forward     = data[CodeWidth-1:0];
            REG_CODE_BACKWARD:    mirror_cfg.code_backward    = data[CodeWidth-1:0];
            REG_CODE_PIVOT_LEFT:  mirror_cfg.code_pivot_left  = data[CodeWidth-1:0];
            REG_CODE_PIVOT_RIGHT: mirror_cfg.code_pivot_right = data[CodeWidth-1:0];
            REG_CODE_HALT:        mirror_cfg.code_halt        = data[CodeWidth-1:0];
            REG_RELEASE_TIMEOUT:  mirror_cfg.release_timeout  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // upper byte of the byte registers is junk that must be dropped
    task automatic program_cfg(cfg_t c);
        wait_drained();
        cfg_write(REG_STATION_ADDR,     {8'($urandom), c.station_addr});
        cfg_write(REG_CODE_FORWARD,     {8'($urandom), c.code_forward});
        cfg_write(REG_CODE_BACKWARD,    {8'($urandom), c.code_backward});
        cfg_write(REG_CODE_PIVOT_LEFT,  {8'($urandom), c.code_pivot_left});
        cfg_write(REG_CODE_PIVOT_RIGHT, {8'($urandom), c.code_pivot_right});
        cfg_write(REG_CODE_HALT,        {8'($urandom), c.code_halt});
        cfg_write(REG_RELEASE_TIMEOUT,  c.release_timeout);
    endtask

    task automatic run_random(int unsigned n);
        int unsigned sent;
        int unsigned run_len;
        remote_req_t r;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                // tick run of random length that can pass a release timeout of at most 400
                if (mirror_cfg.release_timeout <= 400)
                    run_len = $urandom_range(1, int'(mirror_cfg.release_timeout) + 3);
                else
                    run_len = $urandom_range(1, 50);
                repeat (run_len)
                begin
                    r = random_req();
                    r.tick = 1'b1;
                    send_req(r, 1'b0, '0);
                end
                sent += run_len;
            end
            else
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                send_req(random_req(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge clk)
    begin
        rx_cycle++;
        case (rx_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= ((rx_cycle % 11) < 4);
            default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        drive_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_expected.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual heading %0d",
                         $time, heading);
                mismatch_count++;
            end
            else
            begin
                want = drive_expected.pop_front();
                check_field("left_drive",   want.left,      left_drive);
                check_field("right_drive",  want.right,     right_drive);
                check_field("heading",      want.head,      heading);
                check_field("auto_stopped", want.auto_stop, auto_stopped);
                check_field("halt_pressed", want.halt,      halt_pressed);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                   || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles + 1 >= StallLimit)
        begin
            $display("%0t timeout: no request moved for %0d cycles", $time, StallLimit);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        cfg_t        c;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = 1'b0;
        frame_ok       = 1'b0;
        frame_address  = '0;
        frame_command  = '0;
        is_repeat      = 1'b0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mirror_cfg     = CfgDefault;
        mirror_heading = HEAD_NONE;
        mirror_quiet   = '0;
        mismatch_count = 0;
        rx_mode        = 1;
        gaps_on        = 1'b1;
        burst_left     = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        dir_table = '{
            with_exp(req_row(1, 0, 0, 0, 0), DRV_COAST, DRV_COAST, HEAD_NONE, 0, 0),
            with_exp(req_row(0, 1, 0, CodeForwardReset, 0), DRV_FWD, DRV_FWD, HEAD_FWD, 0, 0),
            with_exp(req_row(0, 1, 0, CodeBackwardReset, 0), DRV_REV, DRV_REV, HEAD_BACK, 0, 0),
            with_exp(req_row(0, 1, 0, CodePivotLeftReset, 0), DRV_REV, DRV_FWD, HEAD_LEFT, 0, 0),
            with_exp(req_row(0, 1, 0, CodePivotRightReset, 0), DRV_FWD, DRV_REV, HEAD_RIGHT, 0, 0),
            with_exp(req_row(0, 1, 0, CodeHaltReset, 0), DRV_COAST, DRV_COAST, HEAD_NONE, 0, 1),
            with_exp(req_row(0, 0, 0, CodeForwardReset, 0), DRV_COAST, DRV_COAST, HEAD_NONE, 0, 0),
            with_exp(req_row(0, 1, AddrHigh, CodeForwardReset, 0),
                     DRV_COAST, DRV_COAST, HEAD_NONE, 0, 0),
            with_exp(req_row(0, 1, 0, CodeForwardReset, 1), DRV_COAST, DRV_COAST, HEAD_NONE, 0, 0),
            req_row(0, 1, 0, CodeForwardReset, 0),
            req_row(0, 1, 0, CodeHigh, 0),
            req_row(0, 1, 0, CodeBackwardReset, 1),
            req_row(1, 1, AddrHigh, CodeHigh, 1),
            req_row(0, 1, 0, CodeForwardReset, 1),
            req_row(0, 1, 0, CodeHaltReset, 1),
            req_row(0, 1, 0, CodeHaltReset, 0),
            cfg_row(REG_RELEASE_TIMEOUT, TimeoutMin),
            cfg_row(REG_STATION_ADDR, {8'hA5, AddrHigh}),
            cfg_row(REG_CODE_FORWARD, {8'h5A, CodeLow}),
            cfg_row(REG_CODE_BACKWARD, {8'hFF, CodeLow}),
            cfg_row(REG_CODE_HALT, {8'hC3, CodeLow}),
            cfg_row(REG_CODE_PIVOT_LEFT, {8'h00, CodeHigh}),
            cfg_row(REG_CODE_PIVOT_RIGHT, {8'h3C, CodeHigh}),
            cfg_row(REG_UNUSED, 16'hFFFF),
            // halt wins over colliding direction codes
            with_exp(req_row(0, 1, AddrHigh, CodeLow, 0), DRV_COAST, DRV_COAST, HEAD_NONE, 0, 1),
            req_row(0, 1, AddrHigh, CodeLow, 1),
            with_exp(req_row(0, 1, AddrHigh, CodeHigh, 0), DRV_REV, DRV_FWD, HEAD_LEFT, 0, 0),
            req_row(0, 1, AddrHigh, CodeHigh, 1),
            req_row(1, 0, 0, 0, 0),
            with_exp(req_row(1, 0, 0, 0, 0), DRV_COAST, DRV_COAST, HEAD_NONE, 1, 0),
            req_row(0, 1, AddrHigh, CodeHigh, 1)
        };

        foreach (dir_table[i])
        begin
            if (dir_table[i].is_cfg)
            begin
                wait_drained();
                cfg_write(dir_table[i].idx, dir_table[i].data);
            end
            else
            begin
                send_req(dir_table[i].req, dir_table[i].has_exp, dir_table[i].exp);
            end
        end

        for (int p = 0; p < RandomPhases; p++)
        begin
            c = CfgDefault;
            case (p)
                0:
                begin
                    c.station_addr    = AddrWidth'($urandom);
                    c.release_timeout = QuietWidth'($urandom_range(1, 30));
                end
                1: c.release_timeout = TimeoutMax;
                2:
                begin
                    // tiny code pool so codes collide often
                    c.station_addr     = AddrWidth'($urandom);
                    c.code_forward     = CodeWidth'($urandom_range(0, 3));
                    c.code_backward    = CodeWidth'($urandom_range(0, 3));
                    c.code_pivot_left  = CodeWidth'($urandom_range(0, 3));
                    c.code_pivot_right = CodeWidth'($urandom_range(0, 3));
                    c.code_halt        = CodeWidth'($urandom_range(0, 3));
                    c.release_timeout  = QuietWidth'($urandom_range(1, 10));
                end
                3: c.station_addr = AddrHigh;
                default:
                begin
                    c.station_addr     = AddrWidth'($urandom);
                    c.code_forward     = CodeWidth'($urandom);
                    c.code_backward    = CodeWidth'($urandom);
                    c.code_pivot_left  = CodeWidth'($urandom);
                    c.code_pivot_right = CodeWidth'($urandom);
                    c.code_halt        = CodeWidth'($urandom);
                    c.release_timeout  = QuietWidth'($urandom_range(1, 65534));
                end
            endcase
            rx_mode = p % 4;
            gaps_on = (p != 1);
            program_cfg(c);
            run_random(RandomItems / RandomPhases);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && drive_expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rdrw_pkg.sv
rtl/rdrw_cfg.sv
rtl/remote_drive_release_watchdog.sv
test/tb_remote_drive_release_watchdog.sv
